// ===== sv/cla_pkg.sv =====
// Shared types, register codes and helper functions for the CC line attach detector.
`default_nettype none

package cla_pkg;

    localparam int VOLT_BITS  = 13;
    localparam int COUNT_BITS = 8;
    localparam int DEB_BITS   = 8;
    localparam int CMP_BITS   = 17;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    typedef logic [VOLT_BITS-1:0]  volt_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [DEB_BITS-1:0]   deb_t;
    typedef logic [1:0]            role_t;
    typedef logic [2:0]            reg_idx_t;

    localparam cnt_t CNT_MAX = '1;

    localparam role_t ROLE_DISABLED = 2'd0;
    localparam role_t ROLE_OBSERVER = 2'd1;
    localparam role_t ROLE_SINK     = 2'd2;

    localparam reg_idx_t REG_ROLE      = 3'd0;
    localparam reg_idx_t REG_SRC_THR   = 3'd1;
    localparam reg_idx_t REG_SNK_LOW   = 3'd2;
    localparam reg_idx_t REG_SNK_HIGH  = 3'd3;
    localparam reg_idx_t REG_DEBOUNCE  = 3'd4;

    localparam volt_t RST_SRC_THR  = 13'd2000;
    localparam volt_t RST_SNK_LOW  = 13'd200;
    localparam volt_t RST_SNK_HIGH = 13'd1600;
    localparam deb_t  RST_DEBOUNCE = 8'd5;

    typedef enum logic [1:0] {
        ATT_UNATT = 2'd0,
        ATT_SRC   = 2'd1,
        ATT_ATT   = 2'd2
    } attach_e;

    typedef struct packed {
        role_t role;
        volt_t src_thr;
        volt_t snk_low;
        volt_t snk_high;
        deb_t  debounce;
    } cfg_t;

    typedef struct packed {
        volt_t dut_cc1_mv;
        volt_t dut_cc2_mv;
        volt_t up_cc1_mv;
        volt_t up_cc2_mv;
    } sample_t;

    typedef struct packed {
        attach_e attach;
        cnt_t    src_cnt;
        cnt_t    snk_cnt;
        logic    src_port;
        logic    src_chan;
        logic    snk_port;
        logic    snk_chan;
        logic    mux;
        logic    dut_sel;
        logic    up_sel;
    } state_t;

    typedef struct packed {
        attach_e attach_state;
        logic    state_changed;
        logic    mux_on;
        logic    src_port;
        logic    src_chan;
        logic    snk_port;
        logic    snk_chan;
        logic    dut_select;
        logic    up_select;
    } result_t;

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic cnt_eq(input cnt_t c, input deb_t d);
        return CMP_BITS'(c) == CMP_BITS'(d);
    endfunction

    function automatic logic cnt_ge(input cnt_t c, input deb_t d);
        return CMP_BITS'(c) >= CMP_BITS'(d);
    endfunction

endpackage

`default_nettype wire

// ===== sv/cla_if.sv =====
// Valid/ready channel interfaces for voltage samples and attach results.
`default_nettype none

interface cla_sample_if;
    logic            valid;
    logic            ready;
    cla_pkg::volt_t  dut_cc1_mv;
    cla_pkg::volt_t  dut_cc2_mv;
    cla_pkg::volt_t  up_cc1_mv;
    cla_pkg::volt_t  up_cc2_mv;

    modport source (output valid, output dut_cc1_mv, output dut_cc2_mv,
                    output up_cc1_mv, output up_cc2_mv, input ready);
    modport sink   (input valid, input dut_cc1_mv, input dut_cc2_mv,
                    input up_cc1_mv, input up_cc2_mv, output ready);
endinterface

interface cla_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] attach_state;
    logic       state_changed;
    logic       mux_on;
    logic       src_port;
    logic       src_chan;
    logic       snk_port;
    logic       snk_chan;
    logic       dut_select;
    logic       up_select;

    modport source (output valid, output attach_state, output state_changed,
                    output mux_on, output src_port, output src_chan, output snk_port,
                    output snk_chan, output dut_select, output up_select, input ready);
    modport sink   (input valid, input attach_state, input state_changed,
                    input mux_on, input src_port, input src_chan, input snk_port,
                    input snk_chan, input dut_select, input up_select, output ready);
endinterface

`default_nettype wire

// ===== sv/cla_apb_regs.sv =====
// APB configuration register file for the CC line attach detector.
`default_nettype none

module cla_apb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cla_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [cla_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [cla_pkg::DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output cla_pkg::cfg_t                        cfg
);

    cla_pkg::cfg_t    cfg_reg;
    cla_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = paddr[cla_pkg::ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.role     <= cla_pkg::ROLE_DISABLED;
            cfg_reg.src_thr  <= cla_pkg::RST_SRC_THR;
            cfg_reg.snk_low  <= cla_pkg::RST_SNK_LOW;
            cfg_reg.snk_high <= cla_pkg::RST_SNK_HIGH;
            cfg_reg.debounce <= cla_pkg::RST_DEBOUNCE;
        end
        else if (wr_en)
        begin
            case (idx)
                cla_pkg::REG_ROLE:     cfg_reg.role     <= pwdata[1:0];
                cla_pkg::REG_SRC_THR:  cfg_reg.src_thr  <= pwdata[cla_pkg::VOLT_BITS-1:0];
                cla_pkg::REG_SNK_LOW:  cfg_reg.snk_low  <= pwdata[cla_pkg::VOLT_BITS-1:0];
                cla_pkg::REG_SNK_HIGH: cfg_reg.snk_high <= pwdata[cla_pkg::VOLT_BITS-1:0];
                cla_pkg::REG_DEBOUNCE: cfg_reg.debounce <= pwdata[cla_pkg::DEB_BITS-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            cla_pkg::REG_ROLE:     prdata = cla_pkg::DATA_BITS'(cfg_reg.role);
            cla_pkg::REG_SRC_THR:  prdata = cla_pkg::DATA_BITS'(cfg_reg.src_thr);
            cla_pkg::REG_SNK_LOW:  prdata = cla_pkg::DATA_BITS'(cfg_reg.snk_low);
            cla_pkg::REG_SNK_HIGH: prdata = cla_pkg::DATA_BITS'(cfg_reg.snk_high);
            cla_pkg::REG_DEBOUNCE: prdata = cla_pkg::DATA_BITS'(cfg_reg.debounce);
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/cla_step.sv =====
// Next-state and result logic for one voltage sample.
`default_nettype none

module cla_step (
    input  wire cla_pkg::state_t  st,
    input  wire cla_pkg::sample_t smp,
    input  wire cla_pkg::cfg_t    cfg,
    output cla_pkg::state_t       st_next,
    output cla_pkg::result_t      res
);

    cla_pkg::volt_t  line [4];
    logic [3:0]      src_hit;
    logic [3:0]      snk_hit;
    logic [1:0]      first;
    logic [1:0]      src_idx;
    logic [1:0]      snk_idx;
    cla_pkg::cnt_t   src_inc;
    cla_pkg::cnt_t   snk_inc;
    cla_pkg::state_t n;

    assign line[0] = smp.dut_cc1_mv;
    assign line[1] = smp.dut_cc2_mv;
    assign line[2] = smp.up_cc1_mv;
    assign line[3] = smp.up_cc2_mv;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            src_hit[i] = line[i] > cfg.src_thr;
            snk_hit[i] = (line[i] > cfg.snk_low) && (line[i] < cfg.snk_high);
        end
    end

    always_comb
    begin
        if (src_hit[0])
        begin
            first = 2'd0;
        end
        else if (src_hit[1])
        begin
            first = 2'd1;
        end
        else if (src_hit[2])
        begin
            first = 2'd2;
        end
        else
        begin
            first = 2'd3;
        end
    end

    assign src_idx = {st.src_port, st.src_chan};
    assign snk_idx = {st.snk_port, st.snk_chan};
    assign src_inc = cla_pkg::sat_inc(st.src_cnt);
    assign snk_inc = cla_pkg::sat_inc(st.snk_cnt);

    always_comb
    begin
        n = st;
        case (cfg.role)
            cla_pkg::ROLE_OBSERVER:
            begin
                case (st.attach)
                    cla_pkg::ATT_SRC:
                    begin
                        if (snk_hit[snk_idx] && cla_pkg::cnt_eq(st.snk_cnt, cfg.debounce))
                        begin
                            n.attach  = cla_pkg::ATT_ATT;
                            n.snk_cnt = '0;
                        end
                        else
                        begin
                            if (snk_hit[snk_idx])
                            begin
                                n.snk_cnt = snk_inc;
                            end
                            n.snk_chan = ~st.snk_chan;
                            if (st.snk_port)
                            begin
                                n.up_sel = ~st.snk_chan;
                            end
                            else
                            begin
                                n.dut_sel = ~st.snk_chan;
                            end
                            if (!src_hit[src_idx])
                            begin
                                if (cla_pkg::cnt_eq(st.src_cnt, cfg.debounce))
                                begin
                                    n.attach  = cla_pkg::ATT_UNATT;
                                    n.mux     = 1'b0;
                                    n.src_cnt = '0;
                                end
                                else
                                begin
                                    n.src_cnt = src_inc;
                                end
                            end
                            else
                            begin
                                n.src_cnt = '0;
                            end
                        end
                    end
                    cla_pkg::ATT_ATT:
                    begin
                        if (!snk_hit[snk_idx])
                        begin
                            if (cla_pkg::cnt_eq(st.snk_cnt, cfg.debounce))
                            begin
                                n.attach  = cla_pkg::ATT_UNATT;
                                n.mux     = 1'b0;
                                n.src_cnt = '0;
                            end
                            n.snk_cnt = snk_inc;
                        end
                        else
                        begin
                            n.snk_cnt = '0;
                        end
                    end
                    default:
                    begin
                        if (|src_hit)
                        begin
                            n.src_port = first[1];
                            n.src_chan = first[0];
                            if (cla_pkg::cnt_eq(st.src_cnt, cfg.debounce))
                            begin
                                n.attach   = cla_pkg::ATT_SRC;
                                n.snk_port = ~first[1];
                                n.snk_chan = 1'b0;
                                n.snk_cnt  = '0;
                                n.src_cnt  = '0;
                                n.mux      = 1'b1;
                                if (first[1])
                                begin
                                    n.up_sel  = first[0];
                                    n.dut_sel = 1'b0;
                                end
                                else
                                begin
                                    n.dut_sel = first[0];
                                    n.up_sel  = 1'b0;
                                end
                            end
                            else
                            begin
                                n.src_cnt = src_inc;
                            end
                        end
                        else
                        begin
                            n.src_cnt = '0;
                        end
                    end
                endcase
            end
            cla_pkg::ROLE_SINK:
            begin
                n.mux      = 1'b0;
                n.src_port = 1'b0;
                case (st.attach)
                    cla_pkg::ATT_ATT:
                    begin
                        if (!snk_hit[{1'b0, st.src_chan}])
                        begin
                            if (cla_pkg::cnt_ge(st.src_cnt, cfg.debounce))
                            begin
                                n.attach  = cla_pkg::ATT_UNATT;
                                n.src_cnt = '0;
                            end
                            else
                            begin
                                n.src_cnt = src_inc;
                            end
                        end
                        else
                        begin
                            n.dut_sel = st.src_chan;
                            n.src_cnt = '0;
                        end
                    end
                    cla_pkg::ATT_SRC:
                    begin
                        n.attach = cla_pkg::ATT_ATT;
                    end
                    default:
                    begin
                        n.snk_chan = 1'b0;
                        n.snk_cnt  = '0;
                        if (snk_hit[0] || snk_hit[1])
                        begin
                            n.src_chan = ~snk_hit[0];
                            if (!snk_hit[0])
                            begin
                                n.dut_sel = 1'b1;
                            end
                            if (cla_pkg::cnt_ge(st.src_cnt, cfg.debounce))
                            begin
                                n.attach  = cla_pkg::ATT_ATT;
                                n.src_cnt = '0;
                            end
                            else
                            begin
                                n.src_cnt = src_inc;
                            end
                        end
                        else
                        begin
                            n.src_cnt = '0;
                        end
                    end
                endcase
            end
            default:
            begin
                n.mux     = 1'b0;
                n.attach  = cla_pkg::ATT_UNATT;
                n.src_cnt = '0;
                n.snk_cnt = '0;
            end
        endcase
    end

    assign st_next = n;

    always_comb
    begin
        res.attach_state  = n.attach;
        res.state_changed = n.attach != st.attach;
        res.mux_on        = n.mux;
        res.src_port      = n.src_port;
        res.src_chan      = n.src_chan;
        res.snk_port      = n.snk_port;
        res.snk_chan      = n.snk_chan;
        res.dut_select    = n.dut_sel;
        res.up_select     = n.up_sel;
    end

endmodule

`default_nettype wire

// ===== sv/cc_line_attach_detector.sv =====
// Top level of the USB Type-C CC line attach detector.
//
//   Channel   Direction  Handshake        Word
//   samples   in         valid / ready    four CC line voltages
//   results   out        valid / ready    attach state, mux and selects
//   APB       in         psel / penable   configuration registers
//
// One word is accepted per cycle unless the result channel stalls; a sample is held in
// the input register, and its result is then registered in the result register.
// The whole decision is made by one pass of compare logic between those registers.
// Reset clears the attach state, counters and selects and loads register defaults.
// A stalled result holds in the result register while the next sample waits in
// the input register, so no word is lost under back-pressure.
`default_nettype none

module cc_line_attach_detector (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cla_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [cla_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [cla_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    cla_sample_if.sink                          samples,
    cla_result_if.source                        results
);

    cla_pkg::cfg_t    cfg;
    cla_pkg::sample_t sample_reg;
    logic             in_valid_reg;
    cla_pkg::state_t  state_reg;
    cla_pkg::state_t  state_next;
    cla_pkg::result_t result_reg;
    cla_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             fire;

    cla_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cla_step u_step (
        .st      (state_reg),
        .smp     (sample_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (result_next)
    );

    assign fire          = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            sample_reg.dut_cc1_mv <= samples.dut_cc1_mv;
            sample_reg.dut_cc2_mv <= samples.dut_cc2_mv;
            sample_reg.up_cc1_mv  <= samples.up_cc1_mv;
            sample_reg.up_cc2_mv  <= samples.up_cc2_mv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.attach_state  = result_reg.attach_state;
    assign results.state_changed = result_reg.state_changed;
    assign results.mux_on        = result_reg.mux_on;
    assign results.src_port      = result_reg.src_port;
    assign results.src_chan      = result_reg.src_chan;
    assign results.snk_port      = result_reg.snk_port;
    assign results.snk_chan      = result_reg.snk_chan;
    assign results.dut_select    = result_reg.dut_select;
    assign results.up_select     = result_reg.up_select;

`ifndef NO_ASSERTIONS
    a_mux_needs_attach: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.mux_on) |-> (result_reg.attach_state != cla_pkg::ATT_UNATT))
        else $error("mux enabled while unattached");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (result_reg.state_changed == (state_reg.attach != $past(state_reg.attach))))
        else $error("state_changed disagrees with the attach state update");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("buffered sample dropped without being processed");
`endif

endmodule

`default_nettype wire

// ===== tb/cc_line_attach_detector_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the CC line attach detector, with directed and random voltage samples.

module cc_line_attach_detector_test;
    import cla_pkg::*;

    localparam int    HALF_PERIOD  = 5;
    localparam int    VOLT_TOP     = (1 << VOLT_BITS) - 1;
    localparam int    QUIET_LIMIT  = 4000;
    localparam int    LONG_HOLD    = 300;
    localparam int    DRAIN_CYCLES = 8;
    localparam role_t ROLE_UNUSED  = ROLE_OBSERVER | ROLE_SINK;

    typedef enum int {
        PAT_QUIET,
        PAT_SOURCE,
        PAT_PAIR,
        PAT_DEVICE_SINK,
        PAT_BOUNDARY,
        PAT_NOISE
    } pattern_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    cla_sample_if samp_ch ();
    cla_result_if res_ch ();

    cc_line_attach_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samp_ch),
        .results (res_ch)
    );

    role_t   cfg_role;
    volt_t   cfg_src_thr;
    volt_t   cfg_snk_low;
    volt_t   cfg_snk_high;
    deb_t    cfg_debounce;

    attach_e ln_state;
    cnt_t    ln_src_cnt;
    cnt_t    ln_snk_cnt;
    logic    ln_src_port;
    logic    ln_src_chan;
    logic    ln_snk_port;
    logic    ln_snk_chan;
    logic    ln_mux;
    logic    ln_dut_sel;
    logic    ln_up_sel;
    volt_t   ln_volts [4];

    result_t awaited_decisions [$];

    int      mismatches        = 0;
    int      items_sent        = 0;
    int      decisions_checked = 0;
    int      settings_applied  = 0;
    int      quiet_cycles      = 0;
    logic    sender_steady     = 1'b0;
    logic    receiver_steady   = 1'b0;
    logic    hold_results      = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic cnt_t count_up(input cnt_t c);
        return (&c) ? c : cnt_t'(c + 1'b1);
    endfunction

    function automatic logic sees_source(input volt_t v);
        return v > cfg_src_thr;
    endfunction

    function automatic logic sees_sink(input volt_t v);
        return (v > cfg_snk_low) && (v < cfg_snk_high);
    endfunction

    function automatic volt_t line_volt(input logic port, input logic chan);
        return ln_volts[{port, chan}];
    endfunction

    task automatic route_channel(input logic port, input logic chan);
        if (port)
            ln_up_sel = chan;
        else
            ln_dut_sel = chan;
    endtask

    task automatic observe_tick();
        logic fire;
        logic hit;
        hit  = 1'b0;
        fire = 1'b0;
        if (ln_state == ATT_UNATT)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (!hit && sees_source(ln_volts[i]))
                begin
                    hit = 1'b1;
                    {ln_src_port, ln_src_chan} = 2'(i);
                    fire = (ln_src_cnt == cfg_debounce);
                    ln_src_cnt = count_up(ln_src_cnt);
                    if (fire)
                    begin
                        ln_state    = ATT_SRC;
                        ln_snk_port = ~ln_src_port;
                        ln_snk_chan = 1'b0;
                        ln_snk_cnt  = '0;
                        ln_src_cnt  = '0;
                        ln_mux      = 1'b1;
                        route_channel(ln_src_port, ln_src_chan);
                        route_channel(ln_snk_port, ln_snk_chan);
                    end
                end
            end
            if (!hit)
                ln_src_cnt = '0;
        end
        else if (ln_state == ATT_SRC)
        begin
            if (sees_sink(line_volt(ln_snk_port, ln_snk_chan)))
            begin
                fire = (ln_snk_cnt == cfg_debounce);
                ln_snk_cnt = count_up(ln_snk_cnt);
            end
            if (fire)
            begin
                ln_state   = ATT_ATT;
                ln_snk_cnt = '0;
            end
            else
            begin
                ln_snk_chan = ~ln_snk_chan;
                route_channel(ln_snk_port, ln_snk_chan);
                if (!sees_source(line_volt(ln_src_port, ln_src_chan)))
                begin
                    fire = (ln_src_cnt == cfg_debounce);
                    ln_src_cnt = count_up(ln_src_cnt);
                    if (fire)
                    begin
                        ln_state   = ATT_UNATT;
                        ln_mux     = 1'b0;
                        ln_src_cnt = '0;
                    end
                end
                else
                    ln_src_cnt = '0;
            end
        end
        else
        begin
            if (!sees_sink(line_volt(ln_snk_port, ln_snk_chan)))
            begin
                fire = (ln_snk_cnt == cfg_debounce);
                ln_snk_cnt = count_up(ln_snk_cnt);
                if (fire)
                begin
                    ln_state   = ATT_UNATT;
                    ln_mux     = 1'b0;
                    ln_src_cnt = '0;
                end
            end
            else
                ln_snk_cnt = '0;
        end
    endtask

    task automatic sink_tick();
        logic fire;
        ln_mux      = 1'b0;
        ln_src_port = 1'b0;
        if (ln_state == ATT_UNATT)
        begin
            ln_snk_chan = 1'b0;
            ln_snk_cnt  = '0;
            if (sees_sink(ln_volts[0]) || sees_sink(ln_volts[1]))
            begin
                if (sees_sink(ln_volts[0]))
                    ln_src_chan = 1'b0;
                else
                begin
                    ln_src_chan = 1'b1;
                    ln_dut_sel  = 1'b1;
                end
                fire = (ln_src_cnt >= cfg_debounce);
                ln_src_cnt = count_up(ln_src_cnt);
                if (fire)
                begin
                    ln_state   = ATT_ATT;
                    ln_src_cnt = '0;
                end
            end
            else
                ln_src_cnt = '0;
        end
        else if (ln_state == ATT_ATT)
        begin
            if (!sees_sink(line_volt(1'b0, ln_src_chan)))
            begin
                fire = (ln_src_cnt >= cfg_debounce);
                ln_src_cnt = count_up(ln_src_cnt);
                if (fire)
                begin
                    ln_state   = ATT_UNATT;
                    ln_src_cnt = '0;
                end
            end
            else
            begin
                ln_dut_sel = ln_src_chan;
                ln_src_cnt = '0;
            end
        end
        else
            ln_state = ATT_ATT;
    endtask

    task automatic decide_attach(input sample_t s);
        attach_e prior;
        result_t r;
        ln_volts[0] = s.dut_cc1_mv;
        ln_volts[1] = s.dut_cc2_mv;
        ln_volts[2] = s.up_cc1_mv;
        ln_volts[3] = s.up_cc2_mv;
        prior = ln_state;
        case (cfg_role)
            ROLE_OBSERVER: observe_tick();
            ROLE_SINK:     sink_tick();
            default:
            begin
                ln_mux     = 1'b0;
                ln_state   = ATT_UNATT;
                ln_src_cnt = '0;
                ln_snk_cnt = '0;
            end
        endcase
        r.attach_state  = ln_state;
        r.state_changed = (ln_state != prior);
        r.mux_on        = ln_mux;
        r.src_port      = ln_src_port;
        r.src_chan      = ln_src_chan;
        r.snk_port      = ln_snk_port;
        r.snk_chan      = ln_snk_chan;
        r.dut_select    = ln_dut_sel;
        r.up_select     = ln_up_sel;
        awaited_decisions.insert(awaited_decisions.size(), r);
    endtask

    function automatic sample_t cc_levels(input int d1, input int d2, input int u1, input int u2);
        sample_t s;
        s.dut_cc1_mv = volt_t'(d1);
        s.dut_cc2_mv = volt_t'(d2);
        s.up_cc1_mv  = volt_t'(u1);
        s.up_cc2_mv  = volt_t'(u2);
        return s;
    endfunction

    function automatic volt_t source_volt();
        return (cfg_src_thr == volt_t'(VOLT_TOP)) ? volt_t'(VOLT_TOP)
                                                  : volt_t'($urandom_range(VOLT_TOP, cfg_src_thr + 1));
    endfunction

    function automatic volt_t window_volt();
        if (cfg_snk_high > cfg_snk_low + 1)
            return volt_t'($urandom_range(cfg_snk_high - 1, cfg_snk_low + 1));
        else
            return volt_t'($urandom_range(VOLT_TOP, 0));
    endfunction

    function automatic volt_t quiet_volt();
        int top;
        top = (cfg_snk_low < cfg_src_thr) ? cfg_snk_low : cfg_src_thr;
        return volt_t'($urandom_range(top, 0));
    endfunction

    function automatic volt_t boundary_volt();
        case ($urandom_range(7, 0))
            0:       return cfg_src_thr;
            1:       return volt_t'(cfg_src_thr + 1'b1);
            2:       return cfg_snk_low;
            3:       return volt_t'(cfg_snk_low + 1'b1);
            4:       return volt_t'(cfg_snk_high - 1'b1);
            5:       return cfg_snk_high;
            6:       return '0;
            default: return volt_t'(VOLT_TOP);
        endcase
    endfunction

    function automatic sample_t pattern_sample(input pattern_e pat, input logic sp,
                                               input logic sc, input logic kc);
        volt_t v [4];
        for (int i = 0; i < 4; i++)
            v[i] = quiet_volt();
        case (pat)
            PAT_SOURCE:
                v[{sp, sc}] = source_volt();
            PAT_PAIR:
            begin
                v[{sp, sc}] = source_volt();
                if ($urandom_range(7, 0) != 0)
                    v[{~sp, kc}] = window_volt();
            end
            PAT_DEVICE_SINK:
                v[{1'b0, kc}] = window_volt();
            PAT_BOUNDARY:
                for (int i = 0; i < 4; i++)
                    v[i] = boundary_volt();
            PAT_NOISE:
                for (int i = 0; i < 4; i++)
                    v[i] = volt_t'($urandom_range(VOLT_TOP, 0));
            default: ;
        endcase
        return cc_levels(v[0], v[1], v[2], v[3]);
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(6, 0);
        if (gap > 0)
        begin
            samp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samp_ch.valid      <= 1'b1;
        samp_ch.dut_cc1_mv <= s.dut_cc1_mv;
        samp_ch.dut_cc2_mv <= s.dut_cc2_mv;
        samp_ch.up_cc1_mv  <= s.up_cc1_mv;
        samp_ch.up_cc2_mv  <= s.up_cc2_mv;
        do
            @(posedge clk);
        while (!samp_ch.ready);
        decide_attach(s);
        items_sent++;
    endtask

    task automatic wait_idle();
        samp_ch.valid <= 1'b0;
        while (awaited_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] value);
        int          width;
        logic [31:0] mask;
        logic [31:0] data;
        case (idx)
            REG_ROLE:                              width = 2;
            REG_SRC_THR, REG_SNK_LOW, REG_SNK_HIGH: width = VOLT_BITS;
            REG_DEBOUNCE:                          width = DEB_BITS;
            default:                               width = 0;
        endcase
        mask = (32'h1 << width) - 32'h1;
        data = $urandom_range(1, 0) ? ((value & mask) | ($urandom & ~mask)) : value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROLE:     cfg_role     = data[1:0];
            REG_SRC_THR:  cfg_src_thr  = data[VOLT_BITS-1:0];
            REG_SNK_LOW:  cfg_snk_low  = data[VOLT_BITS-1:0];
            REG_SNK_HIGH: cfg_snk_high = data[VOLT_BITS-1:0];
            REG_DEBOUNCE: cfg_debounce = data[DEB_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input role_t role, input int thr, input int low, input int high,
                             input int deb);
        wait_idle();
        write_reg(REG_SRC_THR, thr);
        write_reg(REG_SNK_LOW, low);
        write_reg(REG_SNK_HIGH, high);
        write_reg(REG_DEBOUNCE, deb);
        if ($urandom_range(2, 0) == 0)
            write_reg($urandom_range(7, REG_DEBOUNCE + 1), $urandom);
        write_reg(REG_ROLE, role);
        settings_applied++;
    endtask

    task automatic run_episodes(input int items, input logic no_gaps);
        int       sent;
        int       run;
        pattern_e pat;
        logic     sp;
        logic     sc;
        logic     kc;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(9, 0))
                0:       pat = PAT_QUIET;
                1, 2:    pat = PAT_SOURCE;
                3, 4, 5: pat = PAT_PAIR;
                6:       pat = PAT_DEVICE_SINK;
                7:       pat = PAT_BOUNDARY;
                default: pat = PAT_NOISE;
            endcase
            if (cfg_role == ROLE_SINK && $urandom_range(1, 0) == 1)
                pat = PAT_DEVICE_SINK;
            if ($urandom_range(1, 0) == 1)
                run = cfg_debounce + 1 + $urandom_range(3, 0);
            else
                run = $urandom_range(cfg_debounce + 3, 1);
            {sp, sc, kc} = 3'($urandom);
            sender_steady = no_gaps || ($urandom_range(4, 0) == 0);
            for (int k = 0; k < run && sent < items; k++)
            begin
                send_sample(pattern_sample(pat, sp, sc, kc));
                sent++;
            end
        end
        sender_steady = 1'b0;
    endtask

    task automatic random_phase(input role_t role, input int thr, input int low, input int high,
                                input int deb, input int items);
        configure(role, thr, low, high, deb);
        run_episodes(items, 1'b0);
    endtask

    task automatic test_disabled_role();
        send_sample(cc_levels(VOLT_TOP, VOLT_TOP, VOLT_TOP, VOLT_TOP));
        send_sample(cc_levels(0, 0, 0, 0));
        configure(ROLE_UNUSED, 2000, 200, 1600, 5);
        send_sample(cc_levels(VOLT_TOP, VOLT_TOP, VOLT_TOP, VOLT_TOP));
    endtask

    task automatic test_observer_flow();
        configure(ROLE_OBSERVER, 2000, 200, 1600, 0);
        send_sample(cc_levels(0, 0, 0, VOLT_TOP));
        send_sample(cc_levels(800, 0, 0, VOLT_TOP));
        send_sample(cc_levels(0, 0, 0, VOLT_TOP));
        send_sample(cc_levels(3000, 0, 0, 0));
        send_sample(cc_levels(0, 0, 0, 0));
        // The source count must start from zero again once the source is found.
        configure(ROLE_OBSERVER, 2000, 200, 1600, 2);
        repeat (4) send_sample(cc_levels(0, 5000, 0, 0));
    endtask

    task automatic test_sink_role();
        configure(ROLE_SINK, 2000, 200, 1600, 1);
        send_sample(cc_levels(0, 0, 0, 0));
        send_sample(cc_levels(0, 0, 0, 0));
        send_sample(cc_levels(0, 0, 0, 0));
        send_sample(cc_levels(0, 1000, 0, 0));
        send_sample(cc_levels(0, 1000, 0, 0));
        send_sample(cc_levels(1000, 1000, VOLT_TOP, VOLT_TOP));
    endtask

    task automatic test_window_edges();
        configure(ROLE_OBSERVER, 2000, 200, 1600, 0);
        send_sample(cc_levels(2000, 0, 0, 0));
        send_sample(cc_levels(2001, 0, 0, 0));
        send_sample(cc_levels(201, 1599, 1600, 200));
        send_sample(cc_levels(VOLT_TOP, 0, 2001, 2000));
        send_sample(cc_levels(0, 0, 0, 0));
    endtask

    task automatic test_random_traffic();
        int low;
        random_phase(ROLE_OBSERVER, 2000, 200, 1600, 2, 150);
        random_phase(ROLE_OBSERVER, 2000, 200, 1600, 0, 120);
        random_phase(ROLE_SINK, 2000, 200, 1600, 3, 150);
        random_phase(ROLE_OBSERVER, 0, 0, VOLT_TOP, 1, 80);
        random_phase(ROLE_OBSERVER, VOLT_TOP, 300, 2500, 4, 60);
        random_phase(ROLE_DISABLED, 2000, 200, 1600, 1, 30);
        random_phase(ROLE_SINK, 3000, 100, 3000, 254, 560);
        low = $urandom_range(400, 0);
        random_phase(ROLE_OBSERVER, $urandom_range(VOLT_TOP, 1700), low,
                     low + $urandom_range(1500, 2), $urandom_range(6, 0), 120);
        random_phase(ROLE_SINK, 2000, 200, 1600, 0, 60);
        random_phase(ROLE_OBSERVER, 1800, 150, 1700, 254, 40);
    endtask

    task automatic test_back_pressure();
        configure(ROLE_OBSERVER, 2000, 200, 1600, 1);
        hold_results = 1'b1;
        run_episodes(40, 1'b1);
    endtask

    task automatic compare_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_decision();
        result_t want;
        if (awaited_decisions.size() == 0)
        begin
            $display("%0t: result word with no sample outstanding, attach_state %0d",
                     $time, res_ch.attach_state);
            mismatches++;
        end
        else
        begin
            want = awaited_decisions.pop_front();
            compare_field("attach_state", want.attach_state, res_ch.attach_state);
            compare_field("state_changed", want.state_changed, res_ch.state_changed);
            compare_field("mux_on", want.mux_on, res_ch.mux_on);
            compare_field("src_port", want.src_port, res_ch.src_port);
            compare_field("src_chan", want.src_chan, res_ch.src_chan);
            compare_field("snk_port", want.snk_port, res_ch.snk_port);
            compare_field("snk_chan", want.snk_chan, res_ch.snk_chan);
            compare_field("dut_select", want.dut_select, res_ch.dut_select);
            compare_field("up_select", want.up_select, res_ch.up_select);
            decisions_checked++;
        end
    endtask

    initial
    begin : result_checker
        int stall;
        forever
        begin
            if (hold_results)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                stall = receiver_steady ? 0 : $urandom_range(6, 0);
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            if ($urandom_range(40, 0) == 0)
                receiver_steady = ~receiver_steady;
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            check_decision();
        end
    end

    always @(posedge clk)
    begin
        if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        samp_ch.valid      = 1'b0;
        samp_ch.dut_cc1_mv = '0;
        samp_ch.dut_cc2_mv = '0;
        samp_ch.up_cc1_mv  = '0;
        samp_ch.up_cc2_mv  = '0;
        cfg_role           = ROLE_DISABLED;
        cfg_src_thr        = RST_SRC_THR;
        cfg_snk_low        = RST_SNK_LOW;
        cfg_snk_high       = RST_SNK_HIGH;
        cfg_debounce       = RST_DEBOUNCE;
        ln_state           = ATT_UNATT;
        ln_src_cnt         = '0;
        ln_snk_cnt         = '0;
        ln_src_port        = 1'b0;
        ln_src_chan        = 1'b0;
        ln_snk_port        = 1'b0;
        ln_snk_chan        = 1'b0;
        ln_mux             = 1'b0;
        ln_dut_sel         = 1'b0;
        ln_up_sel          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_disabled_role();
        test_observer_flow();
        test_sink_role();
        test_window_edges();
        test_random_traffic();
        test_back_pressure();

        wait_idle();
        if (awaited_decisions.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_decisions.size());
            mismatches++;
        end
        $display("Run covered %0d voltage samples under %0d register settings.",
                 items_sent, settings_applied);
        $display("%0d result words compared, %0d field mismatches.", decisions_checked, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
